/* rtl/sst_pkg.sv */
// Shared types and constants for the sender statistics table.
`timescale 1ns / 1ps

package sst_pkg;

    // Number of table slots (2 to 16, since the slot fields are four bits wide).
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    // Width that holds both a slot index and the four-bit slot fields.
    localparam int SEL_W         = (IDX_W > 4) ? IDX_W : 4;
    // Scan counter width, wide enough to hold TABLE_ENTRIES itself.
    localparam int CNT_W         = IDX_W + 1;
    // Width for the range check of a requested slot number.
    localparam int RNG_W         = SEL_W + 1;

    localparam logic [6:0] MAX_LENGTH = 7'd64;

    localparam logic MODE_OBSERVE = 1'b0;
    localparam logic MODE_READ    = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [47:0] sender_mac;
        logic [6:0]  packet_length;
        logic [31:0] arrival_time;
        logic [3:0]  radio_channel;
        logic [3:0]  read_slot;
    } sst_in_t;

    typedef struct packed {
        logic        is_new;
        logic        no_room;
        logic [3:0]  slot;
        logic        entry_used;
        logic [47:0] entry_mac;
        logic [31:0] packet_count;
        logic [31:0] last_time;
        logic [6:0]  last_length;
        logic [3:0]  last_channel;
    } sst_out_t;

    // One stored table slot; the used flag lives in flip-flops beside it.
    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] count;
        logic [31:0] time_ms;
        logic [6:0]  length;
        logic [3:0]  channel;
    } sst_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_WRITE
    } sst_state_t;

endpackage

/* rtl/sender_statistics_table_core.sv */
// Sender statistics table: address lookup, slot claim and per-sender counters.
`timescale 1ns / 1ps

// The block keeps TABLE_ENTRIES slots of per-sender statistics in a single
// synchronous memory with a registered read, plus one used flag per slot in
// flip-flops that reset clears, so the table is empty right after reset with
// no clearing pass. One request is handled at a time and is accepted only
// while the sequencer is idle. A read request fetches its slot at the
// accepting edge, and its result is loaded into the output register from the
// READ state once the output register is free. For an observe request the
// sequencer issues one slot address per cycle through the memory read port,
// compares each slot in the cycle after its read, closes the scan once the
// last compare is done, and then does a single read-modify-write of the
// chosen slot. If the previous result still waits for m_ready when a request
// is ready to finish, the sequencer holds in its READ or WRITE state until
// the output register frees up. Once a result is loaded the sequencer
// returns to idle, where the next request can be accepted. The output
// register lets a new request be accepted while the previous result still
// waits for m_ready.
module sender_statistics_table_core
    import sst_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sst_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sst_out_t m_data
);

    // Slot storage and used flags.
    sst_entry_t               table_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] used_reg;
    sst_entry_t               mem_q_reg;
    logic                     used_q_reg;

    // Sequencer state.
    sst_state_t state_reg, state_next;

    // Request held for the whole lookup.
    sst_in_t req_reg;

    // Scan pipeline: issue counter and the registered compare stage.
    logic [CNT_W-1:0] issue_cnt_reg;
    logic             chk_vld_reg;
    logic [IDX_W-1:0] chk_idx_reg;

    // Scan outcome.
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    sst_entry_t       hit_entry_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // Output register.
    logic     m_valid_reg;
    sst_out_t m_data_reg;

    // Control.
    logic             accept;
    logic             out_free;
    logic             scan_issue;
    logic             out_load;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;

    // Address and range helpers.
    logic [SEL_W-1:0] in_sel;
    logic [SEL_W-1:0] req_sel;
    logic             req_in_range;

    // Result and write-back values.
    logic [IDX_W-1:0] tgt_idx;
    logic [SEL_W-1:0] tgt_sel;
    sst_entry_t       old_entry;
    sst_entry_t       new_entry;
    sst_out_t         result;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign in_sel       = SEL_W'(s_data.read_slot);
    assign req_sel      = SEL_W'(req_reg.read_slot);
    assign req_in_range = ({1'b0, req_sel} < RNG_W'(TABLE_ENTRIES));

    assign scan_issue = (issue_cnt_reg != CNT_W'(TABLE_ENTRIES));

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_data.mode == MODE_READ) ? ST_READ : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Finished once every address is issued and the last compare is done.
                if (!scan_issue && !chk_vld_reg) begin
                    state_next = ST_WRITE;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        wr_en    = 1'b0;
        rd_addr  = req_sel[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                // A read request gets its slot fetched at the accepting edge.
                rd_addr = in_sel[IDX_W-1:0];
            end
            ST_SCAN: begin
                rd_addr = issue_cnt_reg[IDX_W-1:0];
            end
            ST_READ: begin
                out_load = out_free;
            end
            ST_WRITE: begin
                out_load = out_free;
                wr_en    = out_free && (hit_reg || free_reg);
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[tgt_idx] <= new_entry;
        end
        mem_q_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg   <= '0;
            used_q_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                used_reg[tgt_idx] <= 1'b1;
            end
            used_q_reg <= used_reg[rd_addr];
        end
    end

    // Request capture and scan bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_vld_reg <= 1'b0;
        end else if (accept) begin
            chk_vld_reg <= 1'b0;
        end else if (state_reg == ST_SCAN) begin
            chk_vld_reg <= scan_issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg       <= s_data;
            issue_cnt_reg <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
        end else begin
            if (state_reg == ST_SCAN && scan_issue) begin
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                chk_idx_reg   <= issue_cnt_reg[IDX_W-1:0];
            end
            // Compare stage: first matching used slot and first unused slot win.
            if (state_reg == ST_SCAN && chk_vld_reg) begin
                if (used_q_reg && (mem_q_reg.mac == req_reg.sender_mac) && !hit_reg) begin
                    hit_reg       <= 1'b1;
                    hit_idx_reg   <= chk_idx_reg;
                    hit_entry_reg <= mem_q_reg;
                end
                if (!used_q_reg && !free_reg) begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= chk_idx_reg;
                end
            end
        end
    end

    // Update of the chosen slot; a freshly claimed slot starts from zero.
    always_comb begin
        tgt_idx   = hit_reg ? hit_idx_reg : free_idx_reg;
        tgt_sel   = SEL_W'(tgt_idx);
        old_entry = hit_reg ? hit_entry_reg : '0;

        new_entry.mac     = req_reg.sender_mac;
        new_entry.count   = old_entry.count + 32'd1;
        new_entry.time_ms = req_reg.arrival_time;
        new_entry.length  = (req_reg.packet_length > MAX_LENGTH) ?
                            MAX_LENGTH : req_reg.packet_length;
        new_entry.channel = req_reg.radio_channel;
    end

    // Result formatting for both request kinds.
    always_comb begin
        result = '0;
        if (state_reg == ST_READ) begin
            result.slot = req_reg.read_slot;
            // Unused or out-of-range slots read back as all zero.
            if (req_in_range && used_q_reg) begin
                result.entry_used   = 1'b1;
                result.entry_mac    = mem_q_reg.mac;
                result.packet_count = mem_q_reg.count;
                result.last_time    = mem_q_reg.time_ms;
                result.last_length  = mem_q_reg.length;
                result.last_channel = mem_q_reg.channel;
            end
        end else if (hit_reg || free_reg) begin
            result.is_new       = (old_entry.count == 32'd0);
            result.slot         = tgt_sel[3:0];
            result.entry_used   = 1'b1;
            result.entry_mac    = new_entry.mac;
            result.packet_count = new_entry.count;
            result.last_time    = new_entry.time_ms;
            result.last_length  = new_entry.length;
            result.last_channel = new_entry.channel;
        end else begin
            // Unknown sender with every slot taken: nothing is stored.
            result.no_room = 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* tb/sst_result_checker.sv */
// Result checker for the sender statistics table: predicts each result and compares it.
`timescale 1ns / 1ps

module sst_result_checker
    import sst_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  sst_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  sst_out_t m_data,
    output int       failures,
    output int       outstanding
);

    // Predicted copy of the table.
    logic        tbl_used    [TABLE_ENTRIES];
    logic [47:0] tbl_mac     [TABLE_ENTRIES];
    logic [31:0] tbl_count   [TABLE_ENTRIES];
    logic [31:0] tbl_stamp   [TABLE_ENTRIES];
    logic [6:0]  tbl_length  [TABLE_ENTRIES];
    logic [3:0]  tbl_channel [TABLE_ENTRIES];

    sst_out_t expected_results [$];
    sst_out_t want;
    int       mismatch_count = 0;

    function automatic sst_out_t fill_entry(sst_out_t res, int idx);
        res.entry_used   = tbl_used[idx];
        res.entry_mac    = tbl_mac[idx];
        res.packet_count = tbl_count[idx];
        res.last_time    = tbl_stamp[idx];
        res.last_length  = tbl_length[idx];
        res.last_channel = tbl_channel[idx];
        return res;
    endfunction

    // Updates the predicted table for one request and returns its result.
    function automatic sst_out_t apply_request(sst_in_t req);
        sst_out_t res;
        int       hit;
        res = '0;
        hit = -1;
        if (req.mode == MODE_READ) begin
            res.slot = req.read_slot;
            if (int'(req.read_slot) < TABLE_ENTRIES) begin
                res = fill_entry(res, int'(req.read_slot));
            end
            return res;
        end
        for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++) begin
            if (tbl_used[i] && tbl_mac[i] == req.sender_mac) begin
                hit = i;
            end
        end
        // A new sender claims the lowest free slot with a zero count.
        for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++) begin
            if (!tbl_used[i]) begin
                tbl_used[i]  = 1'b1;
                tbl_mac[i]   = req.sender_mac;
                tbl_count[i] = '0;
                hit          = i;
            end
        end
        if (hit < 0) begin
            res.no_room = 1'b1;
            return res;
        end
        res.is_new          = (tbl_count[hit] == 32'd0);
        tbl_count[hit]      = tbl_count[hit] + 32'd1;
        tbl_stamp[hit]      = req.arrival_time;
        tbl_length[hit]     = (req.packet_length > MAX_LENGTH) ? MAX_LENGTH : req.packet_length;
        tbl_channel[hit]    = req.radio_channel;
        res.slot            = 4'(hit);
        return fill_entry(res, hit);
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_val,
                                 input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                tbl_used[i]    = 1'b0;
                tbl_mac[i]     = '0;
                tbl_count[i]   = '0;
                tbl_stamp[i]   = '0;
                tbl_length[i]  = '0;
                tbl_channel[i] = '0;
            end
            expected_results.delete();
        end else begin
            // A result can never belong to a request accepted at the same edge,
            // so results are checked before the new request is predicted.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %p",
                             $time, m_data);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("is_new",       64'(want.is_new),       64'(m_data.is_new));
                    compare_field("no_room",      64'(want.no_room),      64'(m_data.no_room));
                    compare_field("slot",         64'(want.slot),         64'(m_data.slot));
                    compare_field("entry_used",   64'(want.entry_used),   64'(m_data.entry_used));
                    compare_field("entry_mac",    64'(want.entry_mac),    64'(m_data.entry_mac));
                    compare_field("packet_count", 64'(want.packet_count), 64'(m_data.packet_count));
                    compare_field("last_time",    64'(want.last_time),    64'(m_data.last_time));
                    compare_field("last_length",  64'(want.last_length),  64'(m_data.last_length));
                    compare_field("last_channel", 64'(want.last_channel), 64'(m_data.last_channel));
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(apply_request(s_data));
            end
        end
        failures    <= mismatch_count;
        outstanding <= expected_results.size();
    end

endmodule

/* tb/tb.sv */
// Top of the sender statistics table testbench: clock, reset, requests and verdict.
`timescale 1ns / 1ps

// The top drives requests into the table and accepts results with random
// idle gaps on both sides, while the checker beside the block predicts and
// compares every result. Inputs change on the falling clock edge so that the
// block and the checker both see stable values at the rising edge.
module tb;
    import sst_pkg::*;

    localparam int RANDOM_REQUESTS = 400;
    // The receiver stops accepting for a long stretch once, well inside the
    // random phase, so that the output register fills and s_ready drops.
    localparam int HOLD_START      = 2000;
    localparam int HOLD_CYCLES     = 300;
    // Margin to leave after the last result.
    localparam int DRAIN_CYCLES    = 2 * (TABLE_ENTRIES + 3);
    // The slowest legal run is roughly 425 requests plus the long hold;
    // this limit allows several times that.
    localparam int TIMEOUT_NS      = 5_000_000;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    sst_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    sst_out_t m_data;
    int       failures;
    int       outstanding;

    always #10 aclk = ~aclk;

    sender_statistics_table_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    sst_result_checker table_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    // A request with every field random, including values the block must clamp.
    function automatic sst_in_t random_request();
        sst_in_t req;
        req.mode          = ($urandom_range(0, 1) == 0) ? MODE_OBSERVE : MODE_READ;
        req.sender_mac    = 48'({$urandom(), $urandom()});
        req.packet_length = 7'($urandom_range(0, 127));
        req.arrival_time  = $urandom();
        req.radio_channel = 4'($urandom_range(0, 15));
        req.read_slot     = 4'($urandom_range(0, 15));
        return req;
    endfunction

    function automatic sst_in_t make_observe(logic [47:0] mac, logic [6:0] len,
                                             logic [31:0] stamp, logic [3:0] chan);
        sst_in_t req;
        req               = random_request();
        req.mode          = MODE_OBSERVE;
        req.sender_mac    = mac;
        req.packet_length = len;
        req.arrival_time  = stamp;
        req.radio_channel = chan;
        return req;
    endfunction

    function automatic sst_in_t make_read(logic [3:0] slot_no);
        sst_in_t req;
        req           = random_request();
        req.mode      = MODE_READ;
        req.read_slot = slot_no;
        return req;
    endfunction

    // Offers one request, optionally after an idle gap, and returns once the
    // block has accepted it. Valid is only ever changed at a falling edge.
    task automatic send_request(input sst_in_t req, input bit steady);
        int gap;
        gap = steady ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Result side: random back-pressure, calm stretches, and one long hold.
    initial begin : result_sink
        int  stall_left;
        int  cycle_no;
        bit  steady_rx;
        stall_left = 0;
        cycle_no   = 0;
        steady_rx  = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            cycle_no++;
            if (cycle_no % 500 == 0) begin
                steady_rx = ($urandom_range(0, 3) == 0);
            end
            if (cycle_no == HOLD_START) begin
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!steady_rx) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin : request_source
        sst_in_t     req;
        logic [47:0] known_macs [$];
        logic [47:0] mac;
        bit          steady;
        int          roll;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        steady  = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. A read of a slot right after reset must show an
        // empty entry with zero channel.
        send_request(make_read(4'd0), steady);
        // All-ones address with the largest legal length and timestamp.
        send_request(make_observe(48'hFFFF_FFFF_FFFF, 7'd64, 32'hFFFF_FFFF, 4'd14), steady);
        // Same sender again: a hit, no longer new, and an oversize length
        // that is stored as 64.
        send_request(make_observe(48'hFFFF_FFFF_FFFF, 7'd127, 32'd0, 4'd15), steady);
        // An all-zero address must not match the unused slots.
        send_request(make_observe(48'h0, 7'd0, 32'd0, 4'd0), steady);
        send_request(make_read(4'd1), steady);
        send_request(make_read(4'd0), steady);
        send_request(make_read(4'd15), steady);
        send_request(make_observe(48'hFFFF_FFFF_FFFF, 7'd65, 32'd1, 4'd1), steady);
        known_macs.push_back(48'hFFFF_FFFF_FFFF);
        known_macs.push_back(48'h0);

        // Fill the rest of the table, then show that a new sender finds no room.
        for (int k = 2; k < TABLE_ENTRIES; k++) begin
            mac = 48'({$urandom(), $urandom()});
            known_macs.push_back(mac);
            send_request(make_observe(mac, 7'($urandom_range(0, 127)), $urandom(),
                                      4'($urandom_range(1, 14))), steady);
        end
        send_request(make_observe(48'({$urandom(), $urandom()}), 7'd10, 32'd5, 4'd6), steady);
        send_request(make_read(4'd15), steady);
        send_request(make_observe(48'h0, 7'd64, 32'hFFFF_FFFF, 4'd14), steady);

        // Random part: half of them packets from senders already in the table,
        // some from unknown senders, and reads of random slots.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 40 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            req  = random_request();
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                req.mode       = MODE_OBSERVE;
                req.sender_mac = known_macs[$urandom_range(0, known_macs.size() - 1)];
            end else if (roll < 65) begin
                req.mode = MODE_OBSERVE;
            end else begin
                req.mode = MODE_READ;
            end
            send_request(req, steady);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // Wait for every predicted result, then give the block time to show
        // any stray result before the verdict.
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
rtl/sst_pkg.sv
rtl/sender_statistics_table_core.sv
tb/sst_result_checker.sv
tb/tb.sv
